// ===== design/imusgn_pkg.sv =====
// Shared constants, types and helpers for the IMU scaler with gyro notch filters.
// Used by imusgn_mac, imu_scale_and_gyro_notch, imusgn_chk and tb; depends on nothing else.
package imusgn_pkg;

  // Raw count width actually used, coefficient fraction bits, filtered gyro axes.
  localparam int SAMPLE_BITS    = 16;
  localparam int COEF_FRAC_BITS = 28;
  localparam int NUM_AXES       = 3;

  // Fixed formats of the fields and registers.
  localparam int RAW_W    = 16;
  localparam int OUT_W    = 32;
  localparam int SCALE_W  = 24;
  localparam int FEED_W   = 29;
  localparam int MID_W    = 31;
  localparam int FB_W     = 30;
  localparam int CFG_W    = 31;
  localparam int CFG_IDX_W = 3;
  localparam int AXES_MAX = 3;
  localparam int FIELDS   = 6;

  // Shared multiplier operands and the accumulator.
  localparam int MUL_W = 33;
  localparam int ACC_W = 64;

  // Scale products are Q.24; results are Q16.16.
  localparam int SCALE_SHIFT = 8;
  localparam logic signed [ACC_W-1:0] SCALE_RND = ACC_W'(1) << (SCALE_SHIFT - 1);
  localparam logic signed [ACC_W-1:0] FILT_RND  = ACC_W'(1) << (COEF_FRAC_BITS - 1);

  // Sequencer: six scalings, then five products per filtered axis.
  localparam int NUM_SCALE = 6;
  localparam int NSLOT     = NUM_SCALE + 5 * NUM_AXES;
  localparam int SLOT_W    = $clog2(NSLOT + 3);
  localparam int AX_W      = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_SCALE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_SCALE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_FEED   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_MID    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_FB     = 3'd4;

  // Register reset values.
  localparam logic [SCALE_W-1:0]       RST_ACCEL_SCALE = 24'd80336;
  localparam logic [SCALE_W-1:0]       RST_GYRO_SCALE  = 24'd17854;
  localparam logic [FEED_W-1:0]        RST_COEF_FEED   = 29'd240295367;
  localparam logic signed [MID_W-1:0]  RST_COEF_MID    = -31'sd472073277;
  localparam logic signed [FB_W-1:0]   RST_COEF_FB     = 30'sd212152594;

  typedef enum logic {
    OP_SCALE,
    OP_FILT
  } op_kind_e;

  // Control that travels with one multiplication through the shared unit.
  typedef struct packed {
    logic     vld;
    op_kind_e kind;
    logic     first;
    logic     last;
    logic     neg;
    logic [2:0] dst;
  } mac_tag_t;

  // A finished value coming back from the shared unit.
  typedef struct packed {
    logic                    vld;
    op_kind_e                kind;
    logic [2:0]              dst;
    logic signed [OUT_W-1:0] val;
  } mac_res_t;

  function automatic logic signed [OUT_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-OUT_W:0] hi;
    hi = v[ACC_W-1:OUT_W-1];
    if ((&hi) || (~|hi)) begin
      return v[OUT_W-1:0];
    end else if (v[ACC_W-1]) begin
      return {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      return {1'b0, {(OUT_W-1){1'b1}}};
    end
  endfunction

endpackage

// ===== design/imusgn_mac.sv =====
// Shared multiply-accumulate unit: one signed multiplier, product register,
// accumulator and rounding/saturation. Depends on imusgn_pkg.
module imusgn_mac import imusgn_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mac_tag_t                tag_i,
  input  logic signed [MUL_W-1:0] op_a_i,
  input  logic signed [MUL_W-1:0] op_b_i,
  output mac_res_t                res_o
);

  logic signed [2*MUL_W-1:0] mul_full;
  logic signed [ACC_W-1:0]   prod_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic signed [ACC_W-1:0]   acc_d;
  logic signed [ACC_W-1:0]   addend;
  logic signed [ACC_W-1:0]   scale_sum;
  mac_tag_t                  tag1_q;
  logic                      fin_vld_q;
  logic [2:0]                fin_dst_q;

  assign mul_full = op_a_i * op_b_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q    <= '0;
      fin_vld_q <= 1'b0;
    end else begin
      tag1_q    <= tag_i;
      fin_vld_q <= tag1_q.vld && (tag1_q.kind == OP_FILT) && tag1_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q    <= mul_full[ACC_W-1:0];
    acc_q     <= acc_d;
    fin_dst_q <= tag1_q.dst;
  end

  // Feedback terms are subtracted; the first term starts from the rounding offset.
  always_comb begin
    addend = tag1_q.neg ? -prod_q : prod_q;
    acc_d  = acc_q;
    if (tag1_q.vld && (tag1_q.kind == OP_FILT)) begin
      acc_d = (tag1_q.first ? FILT_RND : acc_q) + addend;
    end
  end

  assign scale_sum = prod_q + SCALE_RND;

  // Scale results and filter results never land in the same cycle.
  always_comb begin
    res_o = '0;
    if (fin_vld_q) begin
      res_o.vld  = 1'b1;
      res_o.kind = OP_FILT;
      res_o.dst  = fin_dst_q;
      res_o.val  = sat32(acc_q >>> COEF_FRAC_BITS);
    end else if (tag1_q.vld && (tag1_q.kind == OP_SCALE)) begin
      res_o.vld  = 1'b1;
      res_o.kind = OP_SCALE;
      res_o.dst  = tag1_q.dst;
      res_o.val  = sat32(scale_sum >>> SCALE_SHIFT);
    end
  end

endmodule

// ===== design/imu_scale_and_gyro_notch.sv =====
// Top level of the IMU sample scaler with per-axis gyro notch filters.
// Depends on imusgn_pkg and imusgn_mac.
//
// One input word carries a raw six-axis sample; one output word carries three
// accelerations and three notch-filtered angular rates, all signed Q16.16 and
// saturated to 32 bits. All arithmetic runs through a single 33x33 multiplier
// with an accumulator: six scaling products, then five filter products for
// each filtered gyro axis, one product issued per cycle. The input is ready
// again in the same cycle the result is posted, and it is not ready while a
// sample is being worked on. The finished result sits in an output register,
// so the next sample can be taken while the previous result waits. Coefficient
// and scale registers are written through the plain write port and should only
// change while the block is idle; filter history survives register rewrites
// and is cleared only by reset.
module imu_scale_and_gyro_notch import imusgn_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Input words
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // raw_accel_x[15:0], raw_accel_y[31:16], raw_accel_z[47:32],
  // raw_gyro_x[63:48], raw_gyro_y[79:64], raw_gyro_z[95:80]
  input  logic [FIELDS*RAW_W-1:0] s_axis_tdata,
  // Output words
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // accel_x_out[31:0], accel_y_out[63:32], accel_z_out[95:64],
  // rate_x_out[127:96], rate_y_out[159:128], rate_z_out[191:160]
  output logic [FIELDS*OUT_W-1:0] m_axis_tdata,
  // Configuration writes
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } state_e;

  // Filter product order for one axis.
  localparam logic [2:0] T_FEED_NOW = 3'd0;
  localparam logic [2:0] T_MID_IN   = 3'd1;
  localparam logic [2:0] T_FEED_OLD = 3'd2;
  localparam logic [2:0] T_MID_OUT  = 3'd3;
  localparam logic [2:0] T_FB_OUT   = 3'd4;

  // Configuration registers.
  logic [SCALE_W-1:0]      accel_scale_q;
  logic [SCALE_W-1:0]      gyro_scale_q;
  logic [FEED_W-1:0]       coef_feed_q;
  logic signed [MID_W-1:0] coef_mid_q;
  logic signed [FB_W-1:0]  coef_fb_q;

  // Sequencer and working storage.
  state_e                  state_q;
  logic [SLOT_W-1:0]       slot_q;
  logic [AX_W-1:0]         ax_q;
  logic [2:0]              term_q;
  logic [RAW_W-1:0]        raw_q       [FIELDS];
  logic signed [OUT_W-1:0] accel_res_q [AXES_MAX];
  logic signed [OUT_W-1:0] rate_res_q  [AXES_MAX];
  logic signed [OUT_W-1:0] gsc_q       [NUM_AXES];
  logic                    out_vld_q;
  logic [FIELDS*OUT_W-1:0] out_data_q;

  // Filter history per axis.
  logic signed [OUT_W-1:0] prev_in_q   [NUM_AXES];
  logic signed [OUT_W-1:0] older_in_q  [NUM_AXES];
  logic signed [OUT_W-1:0] prev_out_q  [NUM_AXES];
  logic signed [OUT_W-1:0] older_out_q [NUM_AXES];

  mac_tag_t                tag;
  logic signed [MUL_W-1:0] op_a;
  logic signed [MUL_W-1:0] op_b;
  mac_res_t                res;
  logic [2:0]              sidx;
  logic [RAW_W-1:0]        raw_sel;
  logic [1:0]              gidx;
  logic                    in_acc;
  logic                    issuing;
  logic                    filt_phase;
  logic                    publish;
  logic                    out_free;
  logic [FIELDS*OUT_W-1:0] out_pack;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  assign in_acc     = s_axis_tvalid && s_axis_tready;
  assign issuing    = (state_q == ST_RUN) && (slot_q < SLOT_W'(NSLOT));
  assign filt_phase = (slot_q >= SLOT_W'(NUM_SCALE));
  assign out_free   = !out_vld_q || m_axis_tready;
  // The last filter result is written in the slot just before this one.
  assign publish    = ((state_q == ST_RUN) && (slot_q == SLOT_W'(NSLOT + 2)))
                      || (state_q == ST_HOLD);

  always_comb begin
    for (int i = 0; i < AXES_MAX; i++) begin
      out_pack[i*OUT_W +: OUT_W]              = accel_res_q[i];
      out_pack[(AXES_MAX+i)*OUT_W +: OUT_W]   = rate_res_q[i];
    end
  end

  // Configuration port: unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_scale_q <= RST_ACCEL_SCALE;
      gyro_scale_q  <= RST_GYRO_SCALE;
      coef_feed_q   <= RST_COEF_FEED;
      coef_mid_q    <= RST_COEF_MID;
      coef_fb_q     <= RST_COEF_FB;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ACCEL_SCALE: accel_scale_q <= cfg_data_i[SCALE_W-1:0];
        REG_GYRO_SCALE:  gyro_scale_q  <= cfg_data_i[SCALE_W-1:0];
        REG_COEF_FEED:   coef_feed_q   <= cfg_data_i[FEED_W-1:0];
        REG_COEF_MID:    coef_mid_q    <= cfg_data_i[MID_W-1:0];
        REG_COEF_FB:     coef_fb_q     <= cfg_data_i[FB_W-1:0];
        default: ;
      endcase
    end
  end

  // Operand selection for the shared multiplier. Scale slots come first so the
  // scaled gyro values are stored before the filter products read them.
  always_comb begin
    sidx    = slot_q[2:0];
    raw_sel = raw_q[sidx];
    tag     = '0;
    op_a    = '0;
    op_b    = '0;
    if (issuing && !filt_phase) begin
      tag.vld  = 1'b1;
      tag.kind = OP_SCALE;
      tag.dst  = sidx;
      op_a = (sidx < 3'd3) ? $signed({{(MUL_W-SCALE_W){1'b0}}, accel_scale_q})
                           : $signed({{(MUL_W-SCALE_W){1'b0}}, gyro_scale_q});
      op_b = $signed({{(MUL_W-SAMPLE_BITS){raw_sel[SAMPLE_BITS-1]}},
                      raw_sel[SAMPLE_BITS-1:0]});
    end else if (issuing) begin
      tag.vld   = 1'b1;
      tag.kind  = OP_FILT;
      tag.first = (term_q == T_FEED_NOW);
      tag.last  = (term_q == T_FB_OUT);
      tag.neg   = (term_q == T_MID_OUT) || (term_q == T_FB_OUT);
      tag.dst   = 3'(ax_q);
      case (term_q)
        T_FEED_NOW: begin
          op_a = $signed({{(MUL_W-FEED_W){1'b0}}, coef_feed_q});
          op_b = MUL_W'(gsc_q[ax_q]);
        end
        T_MID_IN: begin
          op_a = MUL_W'(coef_mid_q);
          op_b = MUL_W'(prev_in_q[ax_q]);
        end
        T_FEED_OLD: begin
          op_a = $signed({{(MUL_W-FEED_W){1'b0}}, coef_feed_q});
          op_b = MUL_W'(older_in_q[ax_q]);
        end
        T_MID_OUT: begin
          op_a = MUL_W'(coef_mid_q);
          op_b = MUL_W'(prev_out_q[ax_q]);
        end
        T_FB_OUT: begin
          op_a = MUL_W'(coef_fb_q);
          op_b = MUL_W'(older_out_q[ax_q]);
        end
        default: begin
          op_a = '0;
          op_b = '0;
        end
      endcase
    end
  end

  imusgn_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tag_i  (tag),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .res_o  (res)
  );

  assign gidx = 2'(res.dst - 3'd3);

  // Sequencer, result capture, filter history and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      slot_q    <= '0;
      ax_q      <= '0;
      term_q    <= T_FEED_NOW;
      out_vld_q <= 1'b0;
      for (int i = 0; i < NUM_AXES; i++) begin
        prev_in_q[i]   <= '0;
        older_in_q[i]  <= '0;
        prev_out_q[i]  <= '0;
        older_out_q[i] <= '0;
      end
    end else begin
      // A new word may be posted in the same cycle the old one is taken.
      if (publish && out_free) begin
        out_vld_q <= 1'b1;
      end else if (out_vld_q && m_axis_tready) begin
        out_vld_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            state_q <= ST_RUN;
            slot_q  <= '0;
            ax_q    <= '0;
            term_q  <= T_FEED_NOW;
            for (int i = 0; i < FIELDS; i++) begin
              raw_q[i] <= s_axis_tdata[i*RAW_W +: RAW_W];
            end
          end
        end
        ST_RUN: begin
          if (publish) begin
            if (out_free) begin
              out_data_q <= out_pack;
              state_q    <= ST_IDLE;
            end else begin
              state_q <= ST_HOLD;
            end
          end else begin
            slot_q <= slot_q + 1'b1;
          end
          if (issuing && filt_phase) begin
            if (term_q == T_FB_OUT) begin
              term_q <= T_FEED_NOW;
              ax_q   <= ax_q + 1'b1;
            end else begin
              term_q <= term_q + 3'd1;
            end
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            out_data_q <= out_pack;
            state_q    <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase

      // Results from the shared unit. An unfiltered gyro axis keeps its scaled
      // value as the output; a filtered one is overwritten by the filter.
      if (res.vld) begin
        if (res.kind == OP_SCALE) begin
          if (res.dst < 3'd3) begin
            accel_res_q[res.dst[1:0]] <= res.val;
          end else begin
            rate_res_q[gidx] <= res.val;
            if ({1'b0, gidx} < 3'(NUM_AXES)) begin
              gsc_q[gidx[AX_W-1:0]] <= res.val;
            end
          end
        end else begin
          rate_res_q[res.dst[1:0]]         <= res.val;
          older_in_q[res.dst[AX_W-1:0]]    <= prev_in_q[res.dst[AX_W-1:0]];
          prev_in_q[res.dst[AX_W-1:0]]     <= gsc_q[res.dst[AX_W-1:0]];
          older_out_q[res.dst[AX_W-1:0]]   <= prev_out_q[res.dst[AX_W-1:0]];
          prev_out_q[res.dst[AX_W-1:0]]    <= res.val;
        end
      end
    end
  end

endmodule

// ===== design/imusgn_chk.sv =====
// Port-level checks for imu_scale_and_gyro_notch, attached by a bind.
// Depends on imusgn_pkg for the word widths.
module imusgn_chk import imusgn_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    s_axis_tvalid,
  input logic                    s_axis_tready,
  input logic                    m_axis_tvalid,
  input logic                    m_axis_tready,
  input logic [FIELDS*OUT_W-1:0] m_axis_tdata
);

  // A taken sample keeps the input closed while it is worked on.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input still ready right after a word was taken");

  // A new result is posted exactly when the input opens again.
  a_post_reopens_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $rose(s_axis_tready))
    else $error("result posted without the input reopening");

  // No result can follow an accepted sample in the very next cycle.
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !$rose(m_axis_tvalid))
    else $error("result appeared one cycle after a sample was taken");

  // A stalled result holds its word.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result dropped or changed");

endmodule

bind imu_scale_and_gyro_notch imusgn_chk u_imusgn_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== verif/tb.sv =====
// Self-checking testbench for imu_scale_and_gyro_notch: scaled accel words and
// notch-filtered gyro words are checked against a predictor kept in this file.
// Depends on imusgn_pkg and the imu_scale_and_gyro_notch RTL; nothing else.
module tb import imusgn_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD   = 8;
  localparam int RESET_CYCLES = 5;

  // The watchdog allows for the receiver hold-off plus a full item and gaps.
  localparam int QUIET_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 300;
  // The tail is longer than the wait from taking a sample to posting its word.
  localparam int TAIL_CYCLES  = 40;

  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 72;
  localparam int HOLD_PHASE  = 3;
  localparam int MAX_PRINTS  = 30;

  localparam int ACCEL_FIELDS = 3;
  localparam int SCALE_DROP   = 8;

  // Register indexes that decode to nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  // Largest scale value; coefficient values at half of each coefficient range.
  localparam int SCALE_TOP = 16777215;
  localparam int FEED_TOP  = 268435456;
  localparam int MID_TOP   = 536870912;
  localparam int FB_TOP    = 268435456;
  localparam int NEAR_SPAN = 4194304;

  localparam logic [RAW_W-1:0] RAW_MAX = 16'h7FFF;
  localparam logic [RAW_W-1:0] RAW_MIN = 16'h8000;
  localparam logic signed [OUT_W-1:0] Q16_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [OUT_W-1:0] Q16_MIN = 32'sh8000_0000;
  localparam longint LONG_MAX32 = 64'sd2147483647;
  localparam longint LONG_MIN32 = -64'sd2147483648;

  // Field 0 sits in the lowest bits, exactly as on tdata.
  typedef logic [FIELDS-1:0][RAW_W-1:0] raw_sample_t;
  typedef logic [FIELDS-1:0][OUT_W-1:0] imu_result_t;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_e;
  typedef enum int {SET_RESET, SET_NEAR, SET_WILD, SET_TOP, SET_BOTTOM} setting_e;

  // One line of the directed plan: either a register write or a sample. Rows
  // marked typed carry the accel words by hand; their rates are zero because
  // every notch coefficient is zero (or all history is zero) at that point.
  typedef struct packed {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_W-1:0]     reg_val;
    logic [RAW_W-1:0]     ax, ay, az, gx, gy, gz;
    logic                 typed;
    logic [OUT_W-1:0]     want_ax, want_ay, want_az;
  } plan_row_t;

  localparam int PLAN_LEN = 39;

  plan_row_t plan [PLAN_LEN] = '{
    // Right after reset: zero sample, zero history, zero everywhere.
    '{ROW_SAMPLE, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1, 0, 0, 0},
    // Field extremes under the reset registers, then the filter's response.
    '{ROW_SAMPLE, 0, 0, RAW_MAX, RAW_MIN, 16'd1, RAW_MAX, RAW_MIN, 16'hFFFF,
      1'b0, 0, 0, 0},
    '{ROW_SAMPLE, 0, 0, 16'hFFFF, 0, RAW_MAX, RAW_MIN, RAW_MAX, 0, 1'b0, 0, 0, 0},
    '{ROW_SAMPLE, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0},
    // Zero notch coefficients and a unit-like accel scale: 256 per count.
    '{ROW_WRITE, REG_COEF_FEED, 0, 0, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0},
    '{ROW_WRITE, REG_COEF_MID, 0, 0, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0},
    '{ROW_WRITE, REG_COEF_FB, 0, 0, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0},
    '{ROW_WRITE, REG_ACCEL_SCALE, 31'd65536, 0, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0},
    '{ROW_SAMPLE, 0, 0, RAW_MAX, RAW_MIN, 16'hFFFF, RAW_MAX, RAW_MIN, 16'd12345,
      1'b1, 32'sd8388352, -32'sd8388608, -32'sd256},
    '{ROW_SAMPLE, 0, 0, 16'sd16384, 16'sd1, -16'sd16385, 16'd1, 16'hFFFF, 0,
      1'b1, 32'sd4194304, 32'sd256, -32'sd4194560},
    // A zero accel scale, then writes to unused indexes that must not land.
    '{ROW_WRITE, REG_ACCEL_SCALE, 0, 0, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0},
    '{ROW_WRITE, REG_SPARE_LO, 31'h7FFF_FFFF, 0, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0},
    '{ROW_WRITE, REG_SPARE_LO + 3'd1, 31'h7FFF_FFFF, 0, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0},
    '{ROW_WRITE, REG_SPARE_HI, 31'h7FFF_FFFF, 0, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0},
    '{ROW_SAMPLE, 0, 0, RAW_MAX, RAW_MIN, 16'hFFFF, RAW_MIN, RAW_MAX, 16'hFFFF,
      1'b1, 0, 0, 0},
    // Largest accel scale; notch becomes y = x + x[n-2].
    '{ROW_WRITE, REG_ACCEL_SCALE, 31'(SCALE_TOP), 0, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0},
    '{ROW_WRITE, REG_GYRO_SCALE, 31'd65536, 0, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0},
    '{ROW_WRITE, REG_COEF_FEED, 31'(FEED_TOP), 0, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0},
    '{ROW_SAMPLE, 0, 0, RAW_MAX, RAW_MIN, 0, RAW_MAX, RAW_MIN, 16'd100, 1'b0, 0, 0, 0},
    '{ROW_SAMPLE, 0, 0, RAW_MIN, RAW_MAX, 0, RAW_MAX, RAW_MIN, -16'sd100,
      1'b0, 0, 0, 0},
    '{ROW_SAMPLE, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0},
    // Half the top of both signed coefficient ranges: drives the rates to the rails.
    '{ROW_WRITE, REG_COEF_MID, 31'(MID_TOP), 0, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0},
    '{ROW_WRITE, REG_COEF_FB, 31'(FB_TOP), 0, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0},
    '{ROW_SAMPLE, 0, 0, 16'd1, 16'hFFFF, 16'd2, RAW_MAX, RAW_MAX, RAW_MIN,
      1'b0, 0, 0, 0},
    '{ROW_SAMPLE, 0, 0, RAW_MAX, RAW_MAX, RAW_MAX, RAW_MAX, RAW_MAX, RAW_MIN,
      1'b0, 0, 0, 0},
    '{ROW_SAMPLE, 0, 0, RAW_MIN, RAW_MIN, RAW_MIN, RAW_MIN, RAW_MIN, RAW_MAX,
      1'b0, 0, 0, 0},
    // Half the bottom of both signed coefficient ranges with the largest gyro scale.
    '{ROW_WRITE, REG_COEF_MID, -31'sd536870912, 0, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0},
    '{ROW_WRITE, REG_COEF_FB, -31'sd268435456, 0, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0},
    '{ROW_WRITE, REG_GYRO_SCALE, 31'(SCALE_TOP), 0, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0},
    '{ROW_SAMPLE, 0, 0, RAW_MAX, RAW_MIN, 0, RAW_MAX, RAW_MIN, 16'd1, 1'b0, 0, 0, 0},
    '{ROW_SAMPLE, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0},
    '{ROW_SAMPLE, 0, 0, 16'd7, 16'hFFF9, 0, RAW_MIN, RAW_MAX, 16'hFFFF,
      1'b0, 0, 0, 0},
    // Back to the reset registers; history from the rails is kept.
    '{ROW_WRITE, REG_ACCEL_SCALE, CFG_W'(RST_ACCEL_SCALE), 0, 0, 0, 0, 0, 0,
      1'b0, 0, 0, 0},
    '{ROW_WRITE, REG_GYRO_SCALE, CFG_W'(RST_GYRO_SCALE), 0, 0, 0, 0, 0, 0,
      1'b0, 0, 0, 0},
    '{ROW_WRITE, REG_COEF_FEED, CFG_W'(RST_COEF_FEED), 0, 0, 0, 0, 0, 0,
      1'b0, 0, 0, 0},
    '{ROW_WRITE, REG_COEF_MID, CFG_W'(RST_COEF_MID), 0, 0, 0, 0, 0, 0,
      1'b0, 0, 0, 0},
    '{ROW_WRITE, REG_COEF_FB, CFG_W'(RST_COEF_FB), 0, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0},
    '{ROW_SAMPLE, 0, 0, 16'd1000, -16'sd1000, 16'd4096, 16'd500, -16'sd500, 0,
      1'b0, 0, 0, 0},
    '{ROW_SAMPLE, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0}
  };

  // Register settings of the random phases, in order. The first phase runs
  // with no idling on either side; HOLD_PHASE carries the receiver hold-off.
  setting_e schedule [PHASES] = '{SET_RESET, SET_NEAR, SET_WILD, SET_NEAR,
                                  SET_TOP, SET_NEAR, SET_BOTTOM, SET_RESET};

  // Block ports. Every input has a known value from time zero.
  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  // raw_accel_x, raw_accel_y, raw_accel_z, raw_gyro_x, raw_gyro_y, raw_gyro_z
  logic [FIELDS*RAW_W-1:0]      s_axis_tdata = '0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  // accel_x_out, accel_y_out, accel_z_out, rate_x_out, rate_y_out, rate_z_out
  logic [FIELDS*OUT_W-1:0]      m_axis_tdata;
  logic                         cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]         cfg_idx_i = '0;
  logic [CFG_W-1:0]             cfg_data_i = '0;

  // Predictor copy of the registers, at their reset values.
  logic [SCALE_W-1:0]       accel_k  = RST_ACCEL_SCALE;
  logic [SCALE_W-1:0]       gyro_k   = RST_GYRO_SCALE;
  logic [FEED_W-1:0]        b_outer  = RST_COEF_FEED;
  logic signed [MID_W-1:0]  b_mid    = RST_COEF_MID;
  logic signed [FB_W-1:0]   a_second = RST_COEF_FB;

  // Predictor copy of the notch history per gyro axis: last two inputs and
  // last two outputs, all cleared by the one reset at the start.
  logic signed [OUT_W-1:0] hist_x1 [AXES_MAX] = '{default: '0};
  logic signed [OUT_W-1:0] hist_x2 [AXES_MAX] = '{default: '0};
  logic signed [OUT_W-1:0] hist_y1 [AXES_MAX] = '{default: '0};
  logic signed [OUT_W-1:0] hist_y2 [AXES_MAX] = '{default: '0};

  // Output words still owed by the block, oldest first.
  imu_result_t imu_words_due [$];

  int faults          = 0;
  int samples_taken   = 0;
  int rails_hit       = 0;
  int reg_writes      = 0;
  int quiet_cycles    = 0;
  int hold_left       = 0;
  int holdoffs_asked  = 0;
  int holdoffs_served = 0;
  bit steady          = 1'b0;

  imu_scale_and_gyro_notch dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Clamp a wide value into signed 32 bits.
  function automatic logic signed [OUT_W-1:0] clip32(input longint v);
    if (v > LONG_MAX32) begin
      return Q16_MAX;
    end else if (v < LONG_MIN32) begin
      return Q16_MIN;
    end
    return v[OUT_W-1:0];
  endfunction

  // Count times Q0.24 scale gives Q.24; round half up into Q16.16.
  function automatic logic signed [OUT_W-1:0] scale_q16(input logic [RAW_W-1:0] raw,
                                                        input logic [SCALE_W-1:0] k);
    longint p;
    p = longint'($signed(raw)) * longint'(k);
    p = (p + (64'sd1 <<< (SCALE_DROP - 1))) >>> SCALE_DROP;
    return clip32(p);
  endfunction

  // Expected output word for one sample. Advances the notch history, so it
  // is called exactly once per accepted sample.
  function automatic imu_result_t scale_and_notch(input raw_sample_t s);
    imu_result_t r;
    logic signed [OUT_W-1:0] x, y;
    longint b0, b1, a2, acc;
    int a;
    b0 = longint'(b_outer);
    b1 = longint'(b_mid);
    a2 = longint'(a_second);
    for (a = 0; a < ACCEL_FIELDS; a++) begin
      r[a] = scale_q16(s[a], accel_k);
    end
    for (a = 0; a < AXES_MAX; a++) begin
      x = scale_q16(s[ACCEL_FIELDS + a], gyro_k);
      y = x;
      if (a < NUM_AXES) begin
        // Direct form I with b2 equal to b0 and a1 equal to b1.
        acc = b0 * longint'(x) + b1 * longint'(hist_x1[a]) + b0 * longint'(hist_x2[a])
              - b1 * longint'(hist_y1[a]) - a2 * longint'(hist_y2[a]);
        acc = acc + (64'sd1 <<< (COEF_FRAC_BITS - 1));
        y = clip32(acc >>> COEF_FRAC_BITS);
        hist_x2[a] = hist_x1[a];
        hist_x1[a] = x;
        hist_y2[a] = hist_y1[a];
        hist_y1[a] = y;
      end
      if (y == Q16_MAX || y == Q16_MIN) begin
        rails_hit++;
      end
      r[ACCEL_FIELDS + a] = y;
    end
    return r;
  endfunction

  function automatic string field_label(input int f);
    case (f)
      0: return "accel_x_out";
      1: return "accel_y_out";
      2: return "accel_z_out";
      3: return "rate_x_out";
      4: return "rate_y_out";
      default: return "rate_z_out";
    endcase
  endfunction

  // Random sample: mostly full-range noise, some rail values, some small
  // counts so the filter also sees signals that stay off the rails.
  function automatic raw_sample_t random_sample();
    raw_sample_t s;
    int f, mode;
    mode = $urandom_range(99);
    for (f = 0; f < FIELDS; f++) begin
      if (mode < 60) begin
        s[f] = RAW_W'($urandom());
      end else if (mode < 80) begin
        case ($urandom_range(4))
          0: s[f] = RAW_MAX;
          1: s[f] = RAW_MIN;
          2: s[f] = '0;
          3: s[f] = '1;
          default: s[f] = 16'd1;
        endcase
      end else begin
        s[f] = RAW_W'($urandom_range(0, 512) - 256);
      end
    end
    return s;
  endfunction

  task automatic note_fault(input string msg);
    faults++;
    if (faults <= MAX_PRINTS) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  // Offer one sample and hold it until the block takes it. The valid stays
  // high on return; the caller lowers it only when a gap or a pause follows.
  task automatic push_sample(input raw_sample_t s, input bit typed,
                             input imu_result_t want);
    imu_result_t predicted;
    s_axis_tdata  <= s;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = scale_and_notch(s);
    imu_words_due.push_back(typed ? want : predicted);
    samples_taken++;
  endtask

  // Random sender gap, with junk on the data lines.
  task automatic sender_gap();
    int n;
    if (!steady && $urandom_range(99) < 45) begin
      n = $urandom_range(1, 12);
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= {$urandom(), $urandom(), $urandom()};
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Stop offering and wait until every owed word has come out.
  task automatic drain_words();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (imu_words_due.size() != 0);
  endtask

  // Register write; the predictor copy follows it. Only called when idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    reg_writes++;
    case (idx)
      REG_ACCEL_SCALE: accel_k  = val[SCALE_W-1:0];
      REG_GYRO_SCALE:  gyro_k   = val[SCALE_W-1:0];
      REG_COEF_FEED:   b_outer  = val[FEED_W-1:0];
      REG_COEF_MID:    b_mid    = val[MID_W-1:0];
      REG_COEF_FB:     a_second = val[FB_W-1:0];
      default: ;
    endcase
  endtask

  // Receiver: random tready, a long hold-off when one is asked for, and no
  // idling at all while the steady flag is up.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (holdoffs_asked != holdoffs_served) begin
      holdoffs_served <= holdoffs_served + 1;
      hold_left       <= HOLD_CYCLES;
      m_axis_tready   <= 1'b0;
    end else begin
      m_axis_tready <= steady || ($urandom_range(99) >= 11);
    end
  end

  // Output checker: each word taken is compared field by field with the
  // oldest word owed.
  always @(posedge clk_i) begin : check_words
    imu_result_t want, got;
    int f;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (imu_words_due.size() == 0) begin
        note_fault("output word with no sample waiting for it");
      end else begin
        want = imu_words_due.pop_front();
        for (f = 0; f < FIELDS; f++) begin
          if (got[f] !== want[f]) begin
            note_fault($sformatf("%s got %0d expected %0d", field_label(f),
                                 $signed(got[f]), $signed(want[f])));
          end
        end
      end
    end
  end

  // Watchdog: ends the run if no word moves on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles", QUIET_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    raw_sample_t s;
    imu_result_t want;
    int r, ph, n, off;
    logic [CFG_IDX_W-1:0] spare;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed plan. Writes only happen once every owed word has come out.
    for (r = 0; r < PLAN_LEN; r++) begin
      if (plan[r].kind == ROW_WRITE) begin
        drain_words();
        write_reg(plan[r].reg_idx, plan[r].reg_val);
      end else begin
        s = {plan[r].gz, plan[r].gy, plan[r].gx, plan[r].az, plan[r].ay, plan[r].ax};
        want = '0;
        want[0] = plan[r].want_ax;
        want[1] = plan[r].want_ay;
        want[2] = plan[r].want_az;
        sender_gap();
        push_sample(s, plan[r].typed, want);
      end
    end

    // Random phases, each under its own register setting. History carries
    // over from phase to phase, as it does in the block.
    for (ph = 0; ph < PHASES; ph++) begin
      drain_words();
      steady = (ph == 0);
      case (schedule[ph])
        SET_RESET: begin
          write_reg(REG_ACCEL_SCALE, CFG_W'(RST_ACCEL_SCALE));
          write_reg(REG_GYRO_SCALE, CFG_W'(RST_GYRO_SCALE));
          write_reg(REG_COEF_FEED, CFG_W'(RST_COEF_FEED));
          write_reg(REG_COEF_MID, CFG_W'(RST_COEF_MID));
          write_reg(REG_COEF_FB, CFG_W'(RST_COEF_FB));
        end
        SET_NEAR: begin
          // A notch close to the reset one: stable, so rates stay mostly
          // off the rails while the scales roam.
          write_reg(REG_ACCEL_SCALE, CFG_W'($urandom_range(0, SCALE_TOP)));
          write_reg(REG_GYRO_SCALE, CFG_W'($urandom_range(0, SCALE_TOP)));
          off = int'($urandom_range(0, 2 * NEAR_SPAN)) - NEAR_SPAN;
          write_reg(REG_COEF_FEED, CFG_W'(int'(RST_COEF_FEED) + off));
          off = int'($urandom_range(0, 2 * NEAR_SPAN)) - NEAR_SPAN;
          write_reg(REG_COEF_MID, CFG_W'(int'(RST_COEF_MID) + off));
          off = int'($urandom_range(0, 2 * NEAR_SPAN)) - NEAR_SPAN;
          write_reg(REG_COEF_FB, CFG_W'(int'(RST_COEF_FB) + off));
        end
        SET_WILD: begin
          // Raw bits, out-of-range values included.
          write_reg(REG_ACCEL_SCALE, CFG_W'($urandom()));
          write_reg(REG_GYRO_SCALE, CFG_W'($urandom()));
          write_reg(REG_COEF_FEED, CFG_W'($urandom()));
          write_reg(REG_COEF_MID, CFG_W'($urandom()));
          write_reg(REG_COEF_FB, CFG_W'($urandom()));
        end
        SET_TOP: begin
          write_reg(REG_ACCEL_SCALE, CFG_W'(SCALE_TOP));
          write_reg(REG_GYRO_SCALE, CFG_W'(SCALE_TOP));
          write_reg(REG_COEF_FEED, CFG_W'(FEED_TOP));
          write_reg(REG_COEF_MID, CFG_W'(MID_TOP));
          write_reg(REG_COEF_FB, CFG_W'(FB_TOP));
        end
        default: begin
          write_reg(REG_ACCEL_SCALE, '0);
          write_reg(REG_GYRO_SCALE, CFG_W'(1));
          write_reg(REG_COEF_FEED, '0);
          write_reg(REG_COEF_MID, CFG_W'(-MID_TOP));
          write_reg(REG_COEF_FB, CFG_W'(-FB_TOP));
        end
      endcase
      // A write to an unused index must change nothing.
      spare = REG_SPARE_LO + CFG_IDX_W'($urandom_range(0, REG_SPARE_HI - REG_SPARE_LO));
      write_reg(spare, CFG_W'($urandom()));

      for (n = 0; n < PHASE_ITEMS; n++) begin
        // Long receiver hold-off while the sender keeps offering samples, so
        // the output register fills and the input stalls.
        if (ph == HOLD_PHASE && n == 8) begin
          holdoffs_asked++;
        end
        // Sender pause in mid-phase until the block has emptied.
        if (ph != 0 && n == PHASE_ITEMS / 2) begin
          drain_words();
        end
        sender_gap();
        push_sample(random_sample(), 1'b0, '0);
      end
    end
    steady = 1'b0;

    drain_words();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Ran %0d samples (%0d directed rows) with %0d register writes over %0d phases.",
             samples_taken, PLAN_LEN, reg_writes, PHASES);
    $display("%0d rate words sat on a rail; receiver held off once for %0d cycles.",
             rails_hit, HOLD_CYCLES);
    if (faults == 0 && imu_words_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
